// ===== design/ssd_pkg.sv =====
// Package for the spreadsheet serial date converter.
// Holds widths, calendar constants, reciprocal multipliers, the month start
// table and the modulo-7 helper. No dependencies.
`default_nettype none

package ssd_pkg;

    // Field widths
    localparam int SERIAL_W = 22;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int WDAY_W   = 3;

    // Register stages from input register to result register
    localparam int NUM_STG = 7;

    // Serial range and the fictitious leap day
    localparam logic [SERIAL_W-1:0] LAST_SERIAL      = 22'd2958465;
    localparam logic [SERIAL_W-1:0] FAKE_LEAP_SERIAL = 22'd60;

    // Gregorian cycle lengths in days
    localparam int unsigned DAYS_400Y     = 400 * 365 + 400 / 4 + 400 / 400 - 400 / 100;
    localparam int unsigned DAYS_100Y     = 100 * 365 + 100 / 4 - 100 / 100;
    localparam int unsigned DAYS_4Y       = 4 * 365 + 4 / 4;
    localparam int unsigned DAYS_4Y_SHORT = DAYS_4Y - 1;
    localparam int unsigned DAYS_1Y       = 365;
    localparam int unsigned CYCLE_YEARS   = 400;

    // Day counts run from 1600-03-01, so the leap day closes each cycle.
    // Serial 1 (1900-01-01) maps to three short centuries less Jan and Feb.
    localparam int unsigned EPOCH_YEAR   = 1600;
    localparam int unsigned EPOCH_OFFSET = 3 * DAYS_100Y - 31 - 28 - 1;

    // Fixed results of the special serials
    localparam int unsigned BASE_YEAR  = 1900;
    localparam int unsigned MONTH_JAN  = 1;
    localparam int unsigned MONTH_FEB  = 2;
    localparam int unsigned LEAP_DAY   = 29;
    localparam int unsigned MONTHS_MAR = 3;

    // Internal widths
    localparam int DOE_W = $clog2(DAYS_400Y);
    localparam int ERA_W = 5;
    localparam int Q4_W  = 7;
    localparam int YOE_W = 9;
    localparam int DOY_W = 9;
    localparam int MP_W  = 4;

    // Reciprocals: floor(x / d) == (x * ceil(2^k / d)) >> k when k covers
    // the bits of x plus the bits of d
    localparam int ERA_SHIFT = SERIAL_W + $clog2(DAYS_400Y);
    localparam int Q4_SHIFT  = DOE_W + $clog2(DAYS_4Y_SHORT);
    localparam int Y_SHIFT   = DOE_W + $clog2(DAYS_1Y);

    localparam logic [63:0] ERA_MUL =
        ((64'd1 << ERA_SHIFT) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y);
    localparam logic [63:0] Q4_MUL =
        ((64'd1 << Q4_SHIFT) + 64'(DAYS_4Y_SHORT) - 64'd1) / 64'(DAYS_4Y_SHORT);
    localparam logic [63:0] Y_MUL =
        ((64'd1 << Y_SHIFT) + 64'(DAYS_1Y) - 64'd1) / 64'(DAYS_1Y);

    // First day of each month within a March-based year
    localparam logic [DOY_W-1:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    // Per-item flags carried down the pipeline
    typedef struct packed {
        logic              err;
        logic              zero;
        logic              fake;
        logic [WDAY_W-1:0] wday;
    } t_flags;

    localparam int OCT_DIGITS = (SERIAL_W + 2) / 3;

    // Serial modulo 7: octal digits sum since 8 is 1 modulo 7
    function automatic logic [WDAY_W-1:0] mod7(input logic [SERIAL_W-1:0] v);
        logic [3*OCT_DIGITS-1:0] w;
        logic [5:0]              s;
        logic [3:0]              t;
        w = (3*OCT_DIGITS)'(v);
        s = '0;
        for (int i = 0; i < OCT_DIGITS; i++) begin
            s = s + 6'(w[3*i +: 3]);
        end
        t = 4'(s[5:3]) + 4'(s[2:0]);
        if (t >= 4'd14) begin
            t = t - 4'd14;
        end else if (t >= 4'd7) begin
            t = t - 4'd7;
        end
        return t[WDAY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/ssd_if.sv =====
// Valid/ready channels of the serial date converter: serials in, dates out.
// Depends on ssd_pkg for the field widths.
`default_nettype none

interface ssd_in_if import ssd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SERIAL_W-1:0] serial_day;

    modport source (output valid, output serial_day, input ready);
    modport sink   (input valid, input serial_day, output ready);
endinterface

interface ssd_out_if import ssd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;
    logic [WDAY_W-1:0]  weekday_out;
    logic               range_error;

    modport source (output valid, output year_out, output month_out, output day_out,
                    output weekday_out, output range_error, input ready);
    modport sink   (input valid, input year_out, input month_out, input day_out,
                    input weekday_out, input range_error, output ready);
endinterface

`default_nettype wire

// ===== design/ssd_datapath.sv =====
// Datapath of the serial date converter: seven register stages that split
// the serial into 400-year era, year of era and day of year, then month and day. Uses ssd_pkg.
`default_nettype none

module ssd_datapath import ssd_pkg::*; (
    input  logic                i_clk,
    input  logic [NUM_STG-1:0]  i_load,
    input  logic [SERIAL_W-1:0] i_serial_day,
    output logic [YEAR_W-1:0]   o_year,
    output logic [MONTH_W-1:0]  o_month,
    output logic [DAY_W-1:0]    o_day,
    output logic [WDAY_W-1:0]   o_wday,
    output logic                o_err
);

    // Stage registers
    logic [SERIAL_W-1:0] r_s0_serial;
    logic [SERIAL_W-1:0] r_s1_n;
    logic [ERA_W-1:0]    r_s1_era, r_s2_era, r_s3_era, r_s4_era, r_s5_era;
    logic [DOE_W-1:0]    r_s2_doe, r_s3_doe, r_s4_doe;
    logic [DOE_W-1:0]    r_s3_yn;
    logic [YOE_W-1:0]    r_s4_yoe, r_s5_yoe;
    logic [DOY_W-1:0]    r_s5_doy;
    t_flags              r_s1_flags, r_s2_flags, r_s3_flags, r_s4_flags, r_s5_flags;
    logic [YEAR_W-1:0]   r_year;
    logic [MONTH_W-1:0]  r_month;
    logic [DAY_W-1:0]    r_day;
    logic [WDAY_W-1:0]   r_wday;
    logic                r_err;

    // Next values
    t_flags              n_s1_flags;
    logic [SERIAL_W-1:0] n_s1_n;
    logic [ERA_W-1:0]    n_s1_era;
    logic [DOE_W-1:0]    n_s2_doe;
    logic [DOE_W-1:0]    n_s3_yn;
    logic [YOE_W-1:0]    n_s4_yoe;
    logic [DOY_W-1:0]    n_s5_doy;
    logic [YEAR_W-1:0]   n_year;
    logic [MONTH_W-1:0]  n_month;
    logic [DAY_W-1:0]    n_day;
    logic [WDAY_W-1:0]   n_wday;
    logic                n_err;

    // Intermediate terms
    logic [SERIAL_W-1:0] shifted;
    logic [63:0]         era_prod;
    logic [SERIAL_W-1:0] era_days;
    logic [SERIAL_W-1:0] doe_full;
    logic [63:0]         q4_prod;
    logic [Q4_W-1:0]     q4;
    logic [2:0]          q100;
    logic                q400;
    logic [63:0]         y_prod;
    logic [1:0]          c100;
    logic [DOE_W-1:0]    yoe_days;
    logic [MP_W-1:0]     mp;
    logic [MONTH_W-1:0]  month;

    // Stage 0: flags, drop the fictitious day, era by reciprocal
    always_comb begin
        n_s1_flags.err  = r_s0_serial > LAST_SERIAL;
        n_s1_flags.zero = r_s0_serial == '0;
        n_s1_flags.fake = r_s0_serial == FAKE_LEAP_SERIAL;
        n_s1_flags.wday = mod7(r_s0_serial);
        shifted  = r_s0_serial - SERIAL_W'(r_s0_serial > FAKE_LEAP_SERIAL);
        n_s1_n   = shifted + SERIAL_W'(EPOCH_OFFSET);
        era_prod = 64'(n_s1_n) * ERA_MUL;
        n_s1_era = era_prod[ERA_SHIFT +: ERA_W];
    end

    // Stage 1: day of era
    always_comb begin
        era_days = SERIAL_W'(r_s1_era) * SERIAL_W'(DAYS_400Y);
        doe_full = r_s1_n - era_days;
        n_s2_doe = doe_full[DOE_W-1:0];
    end

    // Stage 2: strip leap days so that a plain divide by 365 gives the year
    always_comb begin
        q4_prod = 64'(r_s2_doe) * Q4_MUL;
        q4      = q4_prod[Q4_SHIFT +: Q4_W];
        q100    = '0;
        for (int k = 1; k <= 4; k++) begin
            q100 = q100 + 3'(r_s2_doe >= DOE_W'(k * DAYS_100Y));
        end
        q400    = r_s2_doe >= DOE_W'(DAYS_400Y - 1);
        n_s3_yn = r_s2_doe - DOE_W'(q4) + DOE_W'(q100) - DOE_W'(q400);
    end

    // Stage 3: year of era
    always_comb begin
        y_prod   = 64'(r_s3_yn) * Y_MUL;
        n_s4_yoe = y_prod[Y_SHIFT +: YOE_W];
    end

    // Stage 4: day of the March-based year
    always_comb begin
        c100 = '0;
        for (int k = 1; k <= 3; k++) begin
            c100 = c100 + 2'(r_s4_yoe >= YOE_W'(k * 100));
        end
        yoe_days = DOE_W'(r_s4_yoe) * DOE_W'(DAYS_1Y) + DOE_W'(r_s4_yoe >> 2) - DOE_W'(c100);
        n_s5_doy = DOY_W'(r_s4_doe - yoe_days);
    end

    // Stage 5: month by start compare, then the special serials
    always_comb begin
        mp = '0;
        for (int j = 1; j < 12; j++) begin
            mp = mp + MP_W'(r_s5_doy >= MONTH_START[j]);
        end
        month = (mp < MP_W'(12 - MONTHS_MAR + 1)) ? MONTH_W'(mp) + MONTH_W'(MONTHS_MAR)
                                                  : MONTH_W'(mp) - MONTH_W'(12 - MONTHS_MAR);
        n_month = month;
        n_day   = DAY_W'(r_s5_doy - MONTH_START[mp] + DOY_W'(1));
        n_year  = YEAR_W'(EPOCH_YEAR) + YEAR_W'(r_s5_era) * YEAR_W'(CYCLE_YEARS)
                + YEAR_W'(r_s5_yoe) + YEAR_W'(month <= MONTH_W'(MONTH_FEB));
        n_wday  = r_s5_flags.wday;
        n_err   = 1'b0;
        if (r_s5_flags.err) begin
            n_year  = '0;
            n_month = '0;
            n_day   = '0;
            n_wday  = '0;
            n_err   = 1'b1;
        end else if (r_s5_flags.zero) begin
            n_year  = YEAR_W'(BASE_YEAR);
            n_month = MONTH_W'(MONTH_JAN);
            n_day   = '0;
        end else if (r_s5_flags.fake) begin
            n_year  = YEAR_W'(BASE_YEAR);
            n_month = MONTH_W'(MONTH_FEB);
            n_day   = DAY_W'(LEAP_DAY);
        end
    end

    // Advance each stage when it is free or its item moves on
    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_s0_serial <= i_serial_day;
        end
        if (i_load[1]) begin
            r_s1_n     <= n_s1_n;
            r_s1_era   <= n_s1_era;
            r_s1_flags <= n_s1_flags;
        end
        if (i_load[2]) begin
            r_s2_doe   <= n_s2_doe;
            r_s2_era   <= r_s1_era;
            r_s2_flags <= r_s1_flags;
        end
        if (i_load[3]) begin
            r_s3_yn    <= n_s3_yn;
            r_s3_doe   <= r_s2_doe;
            r_s3_era   <= r_s2_era;
            r_s3_flags <= r_s2_flags;
        end
        if (i_load[4]) begin
            r_s4_yoe   <= n_s4_yoe;
            r_s4_doe   <= r_s3_doe;
            r_s4_era   <= r_s3_era;
            r_s4_flags <= r_s3_flags;
        end
        if (i_load[5]) begin
            r_s5_doy   <= n_s5_doy;
            r_s5_yoe   <= r_s4_yoe;
            r_s5_era   <= r_s4_era;
            r_s5_flags <= r_s4_flags;
        end
        if (i_load[6]) begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_wday  <= n_wday;
            r_err   <= n_err;
        end
    end

    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;
    assign o_wday  = r_wday;
    assign o_err   = r_err;

endmodule

`default_nettype wire

// ===== design/spreadsheet_serial_date_to_dmy.sv =====
// Spreadsheet serial day (1900 date system) to year, month, day, weekday.
// Depends on ssd_pkg, ssd_in_if / ssd_out_if and ssd_datapath.
//
// Usage:
//   i_in carries one serial_day per item; o_out carries year_out,
//   month_out, day_out, weekday_out and range_error per item, one result
//   for every serial, in order. Both are valid/ready channels.
//   Throughput is one item per cycle while o_out.ready is high. An item
//   accepted at a clock edge passes through seven register stages before
//   it is shown on o_out: three constant-reciprocal multiplies (era,
//   leap-day strip, year of era) each sit between registers, followed by
//   the day-of-year subtract and the month compare.
//   Serials above 9999-12-31 give range_error with all other fields zero.
//   Reset clears every stage's valid bit; the pipeline comes up empty and
//   ready. When the receiver stalls, items move up into empty stages and
//   i_in.ready drops only once every stage holds an item.
`default_nettype none

module spreadsheet_serial_date_to_dmy import ssd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssd_in_if.sink    i_in,
    ssd_out_if.source o_out
);

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] load;

    // A stage loads when empty or when the stage after it loads
    always_comb begin
        load[NUM_STG-1] = !r_vld[NUM_STG-1] || o_out.ready;
        for (int i = NUM_STG - 2; i >= 0; i--) begin
            load[i] = !r_vld[i] || load[i+1];
        end
    end

    // Hold or advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (load[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int i = 1; i < NUM_STG; i++) begin
                if (load[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign i_in.ready  = load[0];
    assign o_out.valid = r_vld[NUM_STG-1];

    ssd_datapath u_datapath (
        .i_clk        (i_clk),
        .i_load       (load),
        .i_serial_day (i_in.serial_day),
        .o_year       (o_out.year_out),
        .o_month      (o_out.month_out),
        .o_day        (o_out.day_out),
        .o_wday       (o_out.weekday_out),
        .o_err        (o_out.range_error)
    );

endmodule

`default_nettype wire

// ===== design/ssd_chk.sv =====
// Port-level checks of the serial date converter, bound to the top level.
// Depends on ssd_pkg for the field widths.
`default_nettype none

module ssd_chk import ssd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [YEAR_W-1:0]  i_year,
    input logic [MONTH_W-1:0] i_month,
    input logic [DAY_W-1:0]   i_day,
    input logic [WDAY_W-1:0]  i_wday,
    input logic               i_err
);

    // An empty result register never blocks the input
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while output is empty");

    // A stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_year)
            && $stable(i_month) && $stable(i_day) && $stable(i_wday) && $stable(i_err))
        else $error("stalled result changed");

    // Range errors carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_err |-> i_year == '0 && i_month == '0 && i_day == '0
            && i_wday == '0)
        else $error("range error with nonzero fields");

    // Good results are real dates
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_err |-> i_month >= MONTH_W'(1) && i_month <= MONTH_W'(12)
            && i_wday <= WDAY_W'(6) && i_year >= YEAR_W'(BASE_YEAR)
            && i_year <= YEAR_W'(9999))
        else $error("result outside the calendar");

    // Day zero only comes from serial zero
    a_day_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_err && i_day == '0 |-> i_year == YEAR_W'(BASE_YEAR)
            && i_month == MONTH_W'(MONTH_JAN) && i_wday == '0)
        else $error("day zero outside serial zero");

endmodule

bind spreadsheet_serial_date_to_dmy ssd_chk u_ssd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_year      (o_out.year_out),
    .i_month     (o_out.month_out),
    .i_day       (o_out.day_out),
    .i_wday      (o_out.weekday_out),
    .i_err       (o_out.range_error)
);

`default_nettype wire
